### rtl/stpk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpk_pkg
// Shared types and constants of the tilt platform kinematics pipeline.
// ----------------------------------------------------------------------------
package stpk_pkg;

  localparam int LANES = 3;

  // arm angle full scale, 1.0 = 90 degrees in Q16
  localparam logic [16:0] T_ONE = 17'd65536;

  // height limit, 80 mm in Q16
  localparam logic [31:0] Z_LIMIT = 32'd5242880;

  localparam logic [2:0] REG_ZERO_A      = 3'd0;
  localparam logic [2:0] REG_ZERO_B      = 3'd1;
  localparam logic [2:0] REG_ZERO_C      = 3'd2;
  localparam logic [2:0] REG_STROKE_GAIN = 3'd3;
  localparam logic [2:0] REG_ROLL_GAIN   = 3'd4;
  localparam logic [2:0] REG_PITCH_GAIN  = 3'd5;
  localparam logic [2:0] REG_MIRROR      = 3'd6;

  typedef struct packed {
    logic [LANES-1:0][16:0] t;
    logic [LANES-1:0][22:0] mag;
    logic [LANES-1:0]       neg;
    logic [LANES-1:0]       sat;
    logic [LANES-1:0]       flag;
  } asin_pkt_t;

endpackage

### rtl/stpk_qsin.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpk_qsin
// Quarter-wave sine, degree 9 odd polynomial in Q30, three lanes, six stages.
// ----------------------------------------------------------------------------
module stpk_qsin #(
  parameter int SIDE_W = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                vld_in,
  input  logic [stpk_pkg::LANES-1:0][30:0]    x_in,
  input  logic [SIDE_W-1:0]                   side_in,
  output logic                                vld_out,
  output logic [stpk_pkg::LANES-1:0][32:0]    y_out,
  output logic [SIDE_W-1:0]                   side_out
);

  localparam int NST = 6;
  localparam int LN  = stpk_pkg::LANES;
  localparam logic signed [32:0] C1 = 33'sd1686629713;
  localparam logic signed [32:0] C3 = -33'sd693598669;
  localparam logic signed [32:0] C5 = 33'sd85569306;
  localparam logic signed [32:0] C7 = -33'sd5026995;
  localparam logic signed [32:0] C9 = 33'sd172272;

  function automatic logic signed [32:0] mac_step(input logic signed [32:0] c,
                                                  input logic signed [32:0] p,
                                                  input logic [31:0] x2);
    logic signed [65:0] m;
    m = 66'(p) * $signed({34'd0, x2});
    return c + 33'(m >>> 30);
  endfunction

  function automatic logic signed [32:0] scale(input logic signed [32:0] p,
                                               input logic [30:0] x);
    logic signed [65:0] m;
    m = 66'(p) * $signed({35'd0, x});
    return 33'(m >>> 30);
  endfunction

  logic [NST-1:0]     vld;
  logic [SIDE_W-1:0]  sd [NST];
  logic [30:0]        xs [5][LN];
  logic [31:0]        x2 [4][LN];
  logic signed [32:0] p  [4][LN];
  logic signed [32:0] y  [LN];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NST-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    sd[0] <= side_in;
    for (int k = 1; k < NST; k++) begin
      sd[k] <= sd[k-1];
    end
    for (int l = 0; l < LN; l++) begin
      xs[0][l] <= x_in[l];
      x2[0][l] <= 32'((62'(x_in[l]) * 62'(x_in[l])) >> 30);
      for (int k = 1; k < 5; k++) begin
        xs[k][l] <= xs[k-1][l];
      end
      for (int k = 1; k < 4; k++) begin
        x2[k][l] <= x2[k-1][l];
      end
      p[0][l] <= mac_step(C7, C9, x2[0][l]);
      p[1][l] <= mac_step(C5, p[0][l], x2[1][l]);
      p[2][l] <= mac_step(C3, p[1][l], x2[2][l]);
      p[3][l] <= mac_step(C1, p[2][l], x2[3][l]);
      y[l]    <= scale(p[3][l], xs[4][l]);
    end
  end

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      y_out[l] = y[l];
    end
  end

  assign vld_out  = vld[NST-1];
  assign side_out = sd[NST-1];

endmodule

### rtl/stpk_asin_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpk_asin_step
// One bit of the arcsine search for all three servos: trial sine, then keep.
// ----------------------------------------------------------------------------
module stpk_asin_step #(
  parameter int BIT = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vld_in,
  input  stpk_pkg::asin_pkt_t  pkt_in,
  output logic                 vld_out,
  output stpk_pkg::asin_pkt_t  pkt_out
);

  localparam int LN = stpk_pkg::LANES;
  localparam logic [16:0] TRIAL = 17'(1) << BIT;

  logic [LN-1:0][30:0]  x_in;
  logic [LN-1:0][32:0]  y_q;
  logic                 vld_q;
  stpk_pkg::asin_pkt_t  pkt_q;
  logic [LN-1:0][16:0]  t_next;
  stpk_pkg::asin_pkt_t  pkt_next;

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      x_in[l] = {pkt_in.t[l] | TRIAL, 14'd0};
    end
  end

  stpk_qsin #(.SIDE_W($bits(stpk_pkg::asin_pkt_t))) u_qsin (
    .clk      (clk),
    .rst      (rst),
    .vld_in   (vld_in),
    .x_in     (x_in),
    .side_in  (pkt_in),
    .vld_out  (vld_q),
    .y_out    (y_q),
    .side_out (pkt_q)
  );

  always_comb begin
    logic [16:0]        cand;
    logic signed [36:0] lhs;
    logic signed [36:0] rhs;
    for (int l = 0; l < LN; l++) begin
      cand = pkt_q.t[l] | TRIAL;
      lhs  = (37'($signed(y_q[l])) <<< 2) + 37'($signed(y_q[l]));
      rhs  = $signed({4'd0, pkt_q.mag[l], 10'd0});
      if (cand <= stpk_pkg::T_ONE && lhs <= rhs) begin
        t_next[l] = cand;
      end else begin
        t_next[l] = pkt_q.t[l];
      end
    end
  end

  always_comb begin
    pkt_next   = pkt_q;
    pkt_next.t = t_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_q;
    end
  end

  always_ff @(posedge clk) begin
    pkt_out <= pkt_next;
  end

  a_t_range: assert property (@(posedge clk) disable iff (rst)
    vld_out |-> (pkt_out.t[0] <= stpk_pkg::T_ONE && pkt_out.t[1] <= stpk_pkg::T_ONE &&
                 pkt_out.t[2] <= stpk_pkg::T_ONE))
    else $error("arm angle above full scale");

endmodule

### rtl/stpk_duty.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpk_duty
// Arm angle to duty around each neutral pulse, rounded, clamped to +-1.
// ----------------------------------------------------------------------------
module stpk_duty (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              vld_in,
  input  stpk_pkg::asin_pkt_t               pkt_in,
  input  logic [stpk_pkg::LANES-1:0][11:0]  zero_pulse,
  output logic                              done,
  output logic [stpk_pkg::LANES-1:0][15:0]  duty,
  output logic [stpk_pkg::LANES-1:0]        flags
);

  localparam int LN = stpk_pkg::LANES;
  // ceil(2^32 / 125)
  localparam logic [25:0] RECIP = 26'd34359739;
  localparam logic signed [30:0] BIAS = 31'sd16384000;
  localparam logic signed [19:0] DUTY_ONE = 20'sd16384;

  logic [1:0]          vld;
  logic [24:0]         u   [LN];
  logic [18:0]         qd  [LN];
  logic [LN-1:0]       fl1;
  logic [LN-1:0]       fl2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[0], vld_in};
      done <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    logic [16:0]        tt;
    logic signed [17:0] ts;
    logic signed [13:0] zs;
    logic signed [30:0] n;
    logic signed [30:0] a;
    logic [50:0]        pr;
    logic signed [19:0] d;
    fl1 <= pkt_in.flag;
    fl2 <= fl1;
    for (int l = 0; l < LN; l++) begin
      // round to nearest: n already holds the +2000, then floor(n / 4000) as /32 then /125
      tt = pkt_in.sat[l] ? stpk_pkg::T_ONE : pkt_in.t[l];
      ts = pkt_in.neg[l] ? -$signed({1'b0, tt}) : $signed({1'b0, tt});
      zs = $signed({2'd0, zero_pulse[l]}) - 14'sd1500;
      n  = (31'(zs) <<< 16) + 31'(ts) * 31'sd1000 + 31'sd2000;
      a  = n >>> 5;
      u[l] <= 25'(a + BIAS);

      pr = 51'(u[l]) * 51'(RECIP);
      qd[l] <= pr[50:32];

      d = $signed({1'b0, qd[l]}) - 20'sd131072;
      if (d > DUTY_ONE) begin
        duty[l]  <= 16'(DUTY_ONE);
        flags[l] <= 1'b1;
      end else if (d < -DUTY_ONE) begin
        duty[l]  <= 16'(-DUTY_ONE);
        flags[l] <= 1'b1;
      end else begin
        duty[l]  <= 16'(d);
        flags[l] <= fl2[l];
      end
    end
  end

endmodule

### rtl/three_servo_tilt_platform_kinematics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_servo_tilt_platform_kinematics
// Throughput: one request per cycle; busy stays low, done cannot be held off.
// The arcsine search takes 17 bits, each a 6-stage sine unit and
// a keep register.
// Synchronous active-high reset clears all valid bits and sets the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module three_servo_tilt_platform_kinematics #(
  parameter int STROKE_WIN_LOW  = 0,
  parameter int STROKE_WIN_HIGH = 65535,
  parameter int ROLL_WIN_LOW    = 0,
  parameter int ROLL_WIN_HIGH   = 65535,
  parameter int PITCH_WIN_LOW   = 0,
  parameter int PITCH_WIN_HIGH  = 65535
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        stroke_pos,
  input  logic [15:0]        roll_pos,
  input  logic [15:0]        pitch_pos,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [15:0]        wr_data,
  output logic               done,
  output logic signed [15:0] duty_a,
  output logic signed [15:0] duty_b,
  output logic signed [15:0] duty_c,
  output logic [2:0]         clamp_flags
);

  localparam int LN      = stpk_pkg::LANES;
  localparam int NBITS   = 17;
  localparam int LATENCY = 135;
  localparam logic signed [23:0] HP_K = 24'sd2270234;

  typedef struct packed {
    logic signed [28:0] stroke;
    logic [LN-1:0]      neg;
  } sin_side_t;

  function automatic logic signed [15:0] axis_centre(input logic [15:0] x,
                                                     input logic signed [17:0] lo,
                                                     input logic signed [17:0] hi,
                                                     input logic mir);
    logic signed [34:0] m;
    logic signed [17:0] w;
    m = 35'(hi - lo) * $signed({19'd0, x});
    w = lo + 18'(m >>> 16);
    if (mir) begin
      w = lo + hi - w;
    end
    return 16'(w - 18'sd32768);
  endfunction

  function automatic logic [30:0] fold(input logic [31:0] ph);
    if (ph[30]) begin
      return 31'h4000_0000 - {1'b0, ph[29:0]};
    end
    return {1'b0, ph[29:0]};
  endfunction

  // configuration
  logic [11:0] zero_pulse_a, zero_pulse_b, zero_pulse_c;
  logic [15:0] stroke_gain, roll_gain, pitch_gain;
  logic [2:0]  mirror_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_pulse_a <= 12'd1500;
      zero_pulse_b <= 12'd1500;
      zero_pulse_c <= 12'd1500;
      stroke_gain  <= 16'd4096;
      roll_gain    <= 16'd4096;
      pitch_gain   <= 16'd4096;
      mirror_flags <= '0;
    end else if (wr_en) begin
      case (wr_index)
        stpk_pkg::REG_ZERO_A:      zero_pulse_a <= wr_data[11:0];
        stpk_pkg::REG_ZERO_B:      zero_pulse_b <= wr_data[11:0];
        stpk_pkg::REG_ZERO_C:      zero_pulse_c <= wr_data[11:0];
        stpk_pkg::REG_STROKE_GAIN: stroke_gain  <= wr_data;
        stpk_pkg::REG_ROLL_GAIN:   roll_gain    <= wr_data;
        stpk_pkg::REG_PITCH_GAIN:  pitch_gain   <= wr_data;
        stpk_pkg::REG_MIRROR:      mirror_flags <= wr_data[2:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // front end: window, products, phases
  logic               v1, v2, v3;
  logic signed [15:0] c_s, c_r, c_p;
  logic signed [32:0] g_s, g_r, g_p;
  logic [LN-1:0][30:0] sx;
  sin_side_t          side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] ph_r, ph_c, ph_p;
    c_s <= axis_centre(stroke_pos, 18'(STROKE_WIN_LOW), 18'(STROKE_WIN_HIGH), mirror_flags[0]);
    c_r <= axis_centre(roll_pos, 18'(ROLL_WIN_LOW), 18'(ROLL_WIN_HIGH), mirror_flags[1]);
    c_p <= axis_centre(pitch_pos, 18'(PITCH_WIN_LOW), 18'(PITCH_WIN_HIGH), mirror_flags[2]);

    g_s <= 33'(c_s) * $signed({17'd0, stroke_gain});
    g_r <= 33'(c_r) * $signed({17'd0, roll_gain});
    g_p <= 33'(c_p) * $signed({17'd0, pitch_gain});

    ph_r = {g_r[29:0], 2'b00};
    ph_c = ph_r + 32'h4000_0000;
    ph_p = {g_p[29:0], 2'b00};
    side3.stroke <= 29'((40'(g_s) * 40'sd100) >>> 12);
    side3.neg    <= {ph_p[31], ph_c[31], ph_r[31]};
    sx[0] <= fold(ph_r);
    sx[1] <= fold(ph_c);
    sx[2] <= fold(ph_p);
  end

  // sines of roll, cos of roll, sine of pitch
  logic                vs;
  logic [LN-1:0][32:0] sy;
  sin_side_t           sside;

  stpk_qsin #(.SIDE_W($bits(sin_side_t))) u_sin (
    .clk      (clk),
    .rst      (rst),
    .vld_in   (v3),
    .x_in     (sx),
    .side_in  (side3),
    .vld_out  (vs),
    .y_out    (sy),
    .side_out (sside)
  );

  // heights
  logic signed [32:0] sr, crs, sp;
  logic               vha, vhb, vhc, vp;
  logic signed [31:0] q_a;
  logic signed [23:0] h1_a, hs_a, h1_b, hs_b, hp_b;
  logic signed [28:0] st_a, st_b;
  logic signed [31:0] z [LN];
  stpk_pkg::asin_pkt_t pkt_p;

  always_comb begin
    sr  = sside.neg[0] ? -$signed(sy[0]) : $signed(sy[0]);
    crs = sside.neg[1] ? -$signed(sy[1]) : $signed(sy[1]);
    sp  = sside.neg[2] ? -$signed(sy[2]) : $signed(sy[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vha <= 1'b0;
      vhb <= 1'b0;
      vhc <= 1'b0;
      vp  <= 1'b0;
    end else begin
      vha <= vs;
      vhb <= vha;
      vhc <= vhb;
      vp  <= vhc;
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] mag;
    q_a  <= 32'((66'(crs) * 66'(sp)) >>> 30);
    h1_a <= 24'((40'(sr) * -40'sd40) >>> 14);
    hs_a <= 24'((40'(sr) * 40'sd20) >>> 14);
    st_a <= sside.stroke;

    hp_b <= 24'((56'(q_a) * 56'(HP_K)) >>> 30);
    h1_b <= h1_a;
    hs_b <= hs_a;
    st_b <= st_a;

    z[0] <= 32'(st_b) + 32'(hs_b) + 32'(hp_b);
    z[1] <= 32'(st_b) + 32'(hs_b) - 32'(hp_b);
    z[2] <= 32'(st_b) + 32'(h1_b);

    for (int l = 0; l < LN; l++) begin
      mag = z[l][31] ? 32'(-z[l]) : 32'(z[l]);
      pkt_p.t[l]    <= '0;
      pkt_p.mag[l]  <= mag[22:0];
      pkt_p.neg[l]  <= z[l][31];
      pkt_p.sat[l]  <= (mag >= stpk_pkg::Z_LIMIT);
      pkt_p.flag[l] <= (mag > stpk_pkg::Z_LIMIT);
    end
  end

  // arcsine search, one bit per step from bit 16 down
  logic                vchain [NBITS+1];
  stpk_pkg::asin_pkt_t pchain [NBITS+1];

  assign vchain[0] = vp;
  assign pchain[0] = pkt_p;

  for (genvar i = 0; i < NBITS; i++) begin : g_step
    stpk_asin_step #(.BIT(NBITS - 1 - i)) u_step (
      .clk     (clk),
      .rst     (rst),
      .vld_in  (vchain[i]),
      .pkt_in  (pchain[i]),
      .vld_out (vchain[i+1]),
      .pkt_out (pchain[i+1])
    );
  end

  logic [LN-1:0][15:0] duty;
  logic [LN-1:0][11:0] zero_pulse;

  assign zero_pulse = {zero_pulse_c, zero_pulse_b, zero_pulse_a};

  stpk_duty u_duty (
    .clk        (clk),
    .rst        (rst),
    .vld_in     (vchain[NBITS]),
    .pkt_in     (pchain[NBITS]),
    .zero_pulse (zero_pulse),
    .done       (done),
    .duty       (duty),
    .flags      (clamp_flags)
  );

  assign duty_a = duty[0];
  assign duty_b = duty[1];
  assign duty_c = duty[2];

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done)
    else $error("result strobe missing after a request");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (duty_a >= -16'sd16384 && duty_a <= 16'sd16384 &&
              duty_b >= -16'sd16384 && duty_b <= 16'sd16384 &&
              duty_c >= -16'sd16384 && duty_c <= 16'sd16384))
    else $error("duty outside +-1");

  a_reset_quiet: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !done)
    else $error("strobe right after reset");

endmodule
